// ----- hdl/res_pkg.sv -----
// ----------------------------------------------------------------------------
// res_pkg
// Shared types and constants of the rainfall event segmenter.
// ----------------------------------------------------------------------------
package res_pkg;

  localparam int MAX_GAP_DEF     = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WET_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_GAP       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_PERCENT  = 2'd2;

  localparam logic [15:0] WET_THRESHOLD_RST = 16'd20;
  localparam logic [3:0]  END_GAP_RST       = 4'd3;
  localparam logic [6:0]  PEAK_PERCENT_RST  = 7'd60;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_EVAL,
    OP_READ,
    OP_DRAIN,
    OP_WET,
    OP_EMIT,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic wet;
    logic in_event;
    logic dry_pending;
    logic close;
    logic drain_done;
    logic last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- hdl/res_ctrl.sv -----
// ----------------------------------------------------------------------------
// res_ctrl
// Sequencer: steps one item through classify, held-dry drain, wet commit,
// series end and record hand-off.
// ----------------------------------------------------------------------------
module res_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  res_pkg::dp_stat_t stat,
  output res_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_READ,
    S_DRAIN,
    S_WET,
    S_FINISH,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = res_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = res_pkg::OP_LOAD;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.op = res_pkg::OP_EVAL;
        if (stat.wet && stat.in_event && stat.dry_pending) begin
          state_nxt = S_READ;
        end else if (stat.wet) begin
          state_nxt = S_WET;
        end else if (stat.in_event && stat.close) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_READ: begin
        cmd.op    = res_pkg::OP_READ;
        state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.op = res_pkg::OP_DRAIN;
        if (stat.drain_done) begin
          state_nxt = S_WET;
        end
      end
      S_WET: begin
        cmd.op    = res_pkg::OP_WET;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (stat.last && stat.in_event) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = res_pkg::OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op    = res_pkg::OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    in_stall_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

  assign in_stall = in_stall_r;

  ap_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == res_pkg::OP_LOAD) |-> (state_r == S_IDLE && !in_stall_r))
    else $error("item taken outside idle");

  ap_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !stat.out_free) |=> (state_r == S_EMIT))
    else $error("record dropped while output full");

  ap_drain_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (state_r == S_DRAIN))
    else $error("drain not started after read");

endmodule

// ----- hdl/res_datapath.sv -----
// ----------------------------------------------------------------------------
// res_datapath
// Event state, held dry-hour store, soil and peak tracking, configuration
// registers and the output record register.
// ----------------------------------------------------------------------------
module res_datapath #(
  parameter int MAX_GAP     = res_pkg::MAX_GAP_DEF,
  parameter int SAMPLE_BITS = res_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  res_pkg::dp_cmd_t                 cmd,
  output res_pkg::dp_stat_t                stat,
  input  logic [SAMPLE_BITS-1:0]           in_precip,
  input  logic [23:0]                      in_soil_capacity,
  input  logic                             in_series_end,
  input  logic                             cfg_we,
  input  logic [res_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [res_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [31:0]                      out_start_hour,
  output logic [15:0]                      out_event_hours,
  output logic [31:0]                      out_total_precip,
  output logic [31:0]                      out_runoff_precip,
  output logic [15:0]                      out_peak_intensity,
  output logic [15:0]                      out_peak_offset,
  output logic                             out_soil_saturated
);

  localparam int DW = $clog2(MAX_GAP + 1);
  localparam int IW = (MAX_GAP > 1) ? $clog2(MAX_GAP) : 1;
  localparam int GW = ((DW > 4) ? DW : 4) + 1;
  localparam int PW = SAMPLE_BITS + 7;

  // configuration
  logic [15:0] wet_thr_r;
  logic [3:0]  end_gap_r;
  logic [6:0]  peak_pct_r;

  // item
  logic [SAMPLE_BITS-1:0] v_r;
  logic [23:0]            cap_r;
  logic                   last_r;

  // held dry hours
  logic [SAMPLE_BITS-1:0] pend_mem [MAX_GAP];
  logic [SAMPLE_BITS-1:0] rd_data_r;
  logic                   mem_we;
  logic                   mem_re;
  logic [IW-1:0]          rd_idx;

  // event state
  logic [31:0]            hour_r, hour_nxt;
  logic                   in_event_r, in_event_nxt;
  logic [DW-1:0]          dry_run_r, dry_run_nxt;
  logic [DW-1:0]          k_r, k_nxt;
  logic [31:0]            start_r, start_nxt;
  logic [15:0]            committed_r, committed_nxt;
  logic [31:0]            total_r, total_nxt;
  logic [23:0]            cap_left_r, cap_left_nxt;
  logic                   sat_r, sat_nxt;
  logic [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic [15:0]            peak_at_r, peak_at_nxt;
  logic [31:0]            rr_r, rr_nxt;
  logic [31:0]            rap_r, rap_nxt;

  logic                   out_valid_r;

  // working values
  logic                   wet;
  logic [GW-1:0]          gap_c;
  logic [SAMPLE_BITS-1:0] cv;
  logic [31:0]            cv32;
  logic [31:0]            cap32;
  logic [32:0]            rr_sum;
  logic [31:0]            rr_add;
  logic [32:0]            tot_sum;
  logic [31:0]            tot_add;
  logic [15:0]            off_inc;
  logic [PW-1:0]          prod_v;
  logic [PW-1:0]          prod_m;
  logic                   commit_en;
  logic                   clr;
  logic [31:0]            max32;
  logic [15:0]            pk;
  logic                   emit;

  assign wet = 32'(v_r) > 32'(wet_thr_r);

  always_comb begin
    if (end_gap_r == 4'd0) begin
      gap_c = GW'(1);
    end else if (GW'(end_gap_r) > GW'(MAX_GAP)) begin
      gap_c = GW'(MAX_GAP);
    end else begin
      gap_c = GW'(end_gap_r);
    end
  end

  assign stat.wet         = wet;
  assign stat.in_event    = in_event_r;
  assign stat.dry_pending = (dry_run_r != '0);
  assign stat.close       = (GW'(dry_run_r) + GW'(1)) >= gap_c;
  assign stat.drain_done  = (k_r == dry_run_r);
  assign stat.last        = last_r;
  assign stat.out_free    = !out_valid_r || !out_stall;

  assign emit      = (cmd.op == res_pkg::OP_EMIT);
  assign commit_en = (cmd.op == res_pkg::OP_DRAIN) || (cmd.op == res_pkg::OP_WET);
  assign clr       = emit || ((cmd.op == res_pkg::OP_FINISH) && last_r);
  assign mem_we    = (cmd.op == res_pkg::OP_EVAL) && !wet && in_event_r;
  assign mem_re    = (cmd.op == res_pkg::OP_READ) ||
                     ((cmd.op == res_pkg::OP_DRAIN) && (k_r != dry_run_r));
  assign rd_idx    = (cmd.op == res_pkg::OP_READ) ? '0 : k_r[IW-1:0];

  always_comb begin
    cv      = (cmd.op == res_pkg::OP_DRAIN) ? rd_data_r : v_r;
    cv32    = 32'(cv);
    cap32   = 32'(cap_left_r);
    rr_sum  = {1'b0, rr_r} + {1'b0, cv32};
    rr_add  = rr_sum[32] ? 32'hFFFF_FFFF : rr_sum[31:0];
    tot_sum = {1'b0, total_r} + {1'b0, 32'(v_r)};
    tot_add = tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];
    off_inc = (committed_r == 16'hFFFF) ? 16'hFFFF : committed_r + 16'd1;
    prod_v  = PW'(cv) * PW'(100);
    prod_m  = PW'(max_r) * PW'(peak_pct_r);

    hour_nxt      = hour_r;
    in_event_nxt  = in_event_r;
    dry_run_nxt   = dry_run_r;
    k_nxt         = k_r;
    start_nxt     = start_r;
    committed_nxt = committed_r;
    total_nxt     = total_r;
    cap_left_nxt  = cap_left_r;
    sat_nxt       = sat_r;
    max_nxt       = max_r;
    peak_at_nxt   = peak_at_r;
    rr_nxt        = rr_r;
    rap_nxt       = rap_r;

    case (cmd.op)
      res_pkg::OP_EVAL: begin
        hour_nxt = (hour_r == 32'hFFFF_FFFF) ? hour_r : hour_r + 32'd1;
        if (wet && !in_event_r) begin
          in_event_nxt = 1'b1;
          start_nxt    = hour_r;
          cap_left_nxt = cap_r;
          if (cap_r == 24'd0) begin
            sat_nxt     = 1'b1;
            rr_nxt      = '0;
            rap_nxt     = '0;
            peak_at_nxt = '0;
            max_nxt     = '0;
          end
        end else if (!wet && in_event_r) begin
          dry_run_nxt = dry_run_r + DW'(1);
          total_nxt   = tot_add;
        end
      end
      res_pkg::OP_READ: begin
        k_nxt = DW'(1);
      end
      res_pkg::OP_DRAIN: begin
        if (k_r != dry_run_r) begin
          k_nxt = k_r + DW'(1);
        end
      end
      res_pkg::OP_WET: begin
        total_nxt   = tot_add;
        dry_run_nxt = '0;
      end
      default: begin
      end
    endcase

    if (commit_en) begin
      committed_nxt = off_inc;
      if (!sat_r) begin
        if (cap32 <= cv32) begin
          sat_nxt     = 1'b1;
          rr_nxt      = cv32 - cap32;
          rap_nxt     = cv32 - cap32;
          peak_at_nxt = off_inc;
          max_nxt     = '0;
        end else begin
          cap_left_nxt = 24'(cap32 - cv32);
        end
      end else begin
        rr_nxt = rr_add;
        if (cv > max_r) begin
          max_nxt     = cv;
          peak_at_nxt = committed_r;
          rap_nxt     = rr_add;
        end else if (prod_v >= prod_m) begin
          peak_at_nxt = committed_r;
          rap_nxt     = rr_add;
        end
      end
    end

    if (clr) begin
      in_event_nxt  = 1'b0;
      dry_run_nxt   = '0;
      start_nxt     = '0;
      committed_nxt = '0;
      total_nxt     = '0;
      cap_left_nxt  = '0;
      sat_nxt       = 1'b0;
      max_nxt       = '0;
      peak_at_nxt   = '0;
      rr_nxt        = '0;
      rap_nxt       = '0;
      if (last_r) begin
        hour_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wet_thr_r   <= res_pkg::WET_THRESHOLD_RST;
      end_gap_r   <= res_pkg::END_GAP_RST;
      peak_pct_r  <= res_pkg::PEAK_PERCENT_RST;
      last_r      <= 1'b0;
      hour_r      <= '0;
      in_event_r  <= 1'b0;
      dry_run_r   <= '0;
      k_r         <= '0;
      start_r     <= '0;
      committed_r <= '0;
      total_r     <= '0;
      cap_left_r  <= '0;
      sat_r       <= 1'b0;
      max_r       <= '0;
      peak_at_r   <= '0;
      rr_r        <= '0;
      rap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          res_pkg::CFG_WET_THRESHOLD: wet_thr_r  <= cfg_data[15:0];
          res_pkg::CFG_END_GAP:       end_gap_r  <= cfg_data[3:0];
          res_pkg::CFG_PEAK_PERCENT:  peak_pct_r <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
      if (cmd.op == res_pkg::OP_LOAD) begin
        last_r <= in_series_end;
      end
      hour_r      <= hour_nxt;
      in_event_r  <= in_event_nxt;
      dry_run_r   <= dry_run_nxt;
      k_r         <= k_nxt;
      start_r     <= start_nxt;
      committed_r <= committed_nxt;
      total_r     <= total_nxt;
      cap_left_r  <= cap_left_nxt;
      sat_r       <= sat_nxt;
      max_r       <= max_nxt;
      peak_at_r   <= peak_at_nxt;
      rr_r        <= rr_nxt;
      rap_r       <= rap_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (cmd.op == res_pkg::OP_LOAD) begin
      v_r   <= in_precip;
      cap_r <= in_soil_capacity;
    end
  end

  // held dry-hour store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pend_mem[dry_run_r[IW-1:0]] <= v_r;
    end
    if (mem_re) begin
      rd_data_r <= pend_mem[rd_idx];
    end
  end

  assign max32 = 32'(max_r);
  assign pk    = (max32 > 32'h0000_FFFF) ? 16'hFFFF : max32[15:0];

  // record register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_start_hour     <= start_r;
      out_event_hours    <= committed_r;
      out_total_precip   <= total_r;
      out_runoff_precip  <= sat_r ? rap_r : 32'd0;
      out_peak_intensity <= sat_r ? pk : 16'd0;
      out_peak_offset    <= sat_r ? peak_at_r : 16'd0;
      out_soil_saturated <= sat_r;
    end
  end

  assign out_valid = out_valid_r;

  ap_dry_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(dry_run_r) <= 32'(MAX_GAP))
    else $error("held dry count beyond store depth");

  ap_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !in_event_r |-> (committed_r == 16'd0 && dry_run_r == '0 && total_r == 32'd0))
    else $error("event state left over outside an event");

  ap_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || !out_stall))
    else $error("record overwritten while stalled");

  ap_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("record not presented after close");

endmodule

// ----- hdl/rainfall_event_segmenter_top.sv -----
// ----------------------------------------------------------------------------
// rainfall_event_segmenter_top
// Splits a series of hourly rain samples into events, one record per event.
//
// Input channel (in_*): one hourly sample per item with the soil capacity and
// a series end mark; taken when in_valid is high and in_stall is low.
// Result channel (out_*): one record when an event closes, held in an output
// register; taken when out_valid is high and out_stall is low.
// Configuration (cfg_*): cfg_ready is always high; cfg_index selects wet
// threshold, end gap or peak percent. Write only between items.
// Per item: a dry hour is loaded, classified and finished; a wet hour adds
// a commit; a wet hour that commits n held dry hours (n at most MAX_GAP - 1)
// first reads them back from the dry-hour store, one entry a cycle. An item
// that closes an event by the gap goes to the hand-off instead; a series end
// that closes an event adds a hand-off; the record is valid in the next cycle.
// Reset clears all event state and restores the register defaults.
// A stalled receiver holds the record; an item that closes another event
// then waits in the hand-off state and in_stall stays high.
// ----------------------------------------------------------------------------
module rainfall_event_segmenter_top #(
  parameter int MAX_GAP     = res_pkg::MAX_GAP_DEF,
  parameter int SAMPLE_BITS = res_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [SAMPLE_BITS-1:0]         in_precip,
  input  logic [23:0]                    in_soil_capacity,
  input  logic                           in_series_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    out_start_hour,
  output logic [15:0]                    out_event_hours,
  output logic [31:0]                    out_total_precip,
  output logic [31:0]                    out_runoff_precip,
  output logic [15:0]                    out_peak_intensity,
  output logic [15:0]                    out_peak_offset,
  output logic                           out_soil_saturated,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [res_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [res_pkg::CFG_DATA_W-1:0] cfg_data
);

  res_pkg::dp_cmd_t  cmd;
  res_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  res_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  res_datapath #(
    .MAX_GAP     (MAX_GAP),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_precip          (in_precip),
    .in_soil_capacity   (in_soil_capacity),
    .in_series_end      (in_series_end),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_start_hour     (out_start_hour),
    .out_event_hours    (out_event_hours),
    .out_total_precip   (out_total_precip),
    .out_runoff_precip  (out_runoff_precip),
    .out_peak_intensity (out_peak_intensity),
    .out_peak_offset    (out_peak_offset),
    .out_soil_saturated (out_soil_saturated)
  );

endmodule
